// File: src/skt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the scalar Kalman tracker.
// ----------------------------------------------------------------------------
package skt_pkg;

  parameter int unsigned GainFracBits = 16;
  parameter int unsigned ValW         = 32;
  parameter int unsigned GainOutW     = 17;
  parameter int unsigned StatusW      = 2;
  parameter int unsigned CfgIdxW      = 8;

  // register indexes
  parameter logic [CfgIdxW-1:0] CfgProcNoise = 8'd0;
  parameter logic [CfgIdxW-1:0] CfgMeasNoise = 8'd1;
  parameter logic [CfgIdxW-1:0] CfgInitEst   = 8'd2;
  parameter logic [CfgIdxW-1:0] CfgInitCov   = 8'd3;

  // register reset values
  parameter logic [ValW-1:0] ProcNoiseRst = 32'h0001_0000;
  parameter logic [ValW-1:0] MeasNoiseRst = 32'h0001_0000;
  parameter logic [ValW-1:0] InitEstRst   = 32'h0000_0000;
  parameter logic [ValW-1:0] InitCovRst   = 32'h0001_0000;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StZeroDen = 2'd1,
    StCovSat  = 2'd2
  } status_e;

  typedef struct packed {
    logic capture;
    logic psum;
    logic dsum;
    logic nsum;
    logic div_step;
    logic gsel;
    logic mest;
    logic mcov;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

// File: src/skt_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_intf
// Measurement, result and register write channels of the Kalman tracker.
// ----------------------------------------------------------------------------
interface skt_meas_if;
  logic                            valid;
  logic                            ready;
  logic signed [skt_pkg::ValW-1:0] measurement;
  logic                            restart;
  logic                            last_sample;

  modport source (output valid, output measurement, output restart, output last_sample,
                  input ready);
  modport sink   (input valid, input measurement, input restart, input last_sample,
                  output ready);
endinterface

interface skt_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [skt_pkg::ValW-1:0]    estimate;
  logic [skt_pkg::GainOutW-1:0]       gain;
  logic [skt_pkg::StatusW-1:0]        status;
  logic                               last_result;

  modport source (output valid, output estimate, output gain, output status,
                  output last_result, input ready);
  modport sink   (input valid, input estimate, input gain, input status,
                  input last_result, output ready);
endinterface

interface skt_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [skt_pkg::CfgIdxW-1:0]  index;
  logic [skt_pkg::ValW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/scalar_kalman_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scalar_kalman_tracker
// One-dimensional fixed-point Kalman tracker, one result beat per measurement.
// ----------------------------------------------------------------------------
// Each measurement beat adds the process noise to the covariance (saturating),
// forms the gain p/(p+r), blends the estimate towards the measurement and
// shrinks the covariance. One beat is worked on at a time: a beat is taken,
// and the next beat can be taken once its result is ready. The restoring
// divider forms the gain one quotient bit per cycle. The result sits in
// an output register, so a new measurement is taken while a finished
// result waits. Register writes are always ready and should only be made
// while idle.
// ----------------------------------------------------------------------------
module scalar_kalman_tracker #(
  parameter int unsigned GAIN_FRAC_BITS = skt_pkg::GainFracBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_meas_if.sink  meas_i,
  skt_res_if.source res_o,
  skt_cfg_if.sink   cfg_i
);

  skt_pkg::cmd_t cmd;
  skt_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (meas_i.valid),
    .in_ready_o  (meas_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  skt_dp #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .meas_i     (meas_i.measurement),
    .restart_i  (meas_i.restart),
    .last_i     (meas_i.last_sample),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .estimate_o (res_o.estimate),
    .gain_o     (res_o.gain),
    .status_o   (res_o.status),
    .last_o     (res_o.last_result)
  );

endmodule

// File: src/skt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer of the tracker: steps the datapath through one update per beat.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  skt_pkg::sts_t  sts_i,
  output skt_pkg::cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    StIdle = 9'b000000001,
    StPsum = 9'b000000010,
    StDsum = 9'b000000100,
    StNsum = 9'b000001000,
    StDiv  = 9'b000010000,
    StGsel = 9'b000100000,
    StMest = 9'b001000000,
    StMcov = 9'b010000000,
    StDone = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = StPsum;
        end
      end
      StPsum: begin
        cmd_o.psum = 1'b1;
        state_d    = StDsum;
      end
      StDsum: begin
        cmd_o.dsum = 1'b1;
        state_d    = StNsum;
      end
      StNsum: begin
        cmd_o.nsum = 1'b1;
        state_d    = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StGsel;
        end
      end
      StGsel: begin
        cmd_o.gsel = 1'b1;
        state_d    = StMest;
      end
      StMest: begin
        cmd_o.mest = 1'b1;
        state_d    = StMcov;
      end
      StMcov: begin
        cmd_o.mcov = 1'b1;
        state_d    = StDone;
      end
      StDone: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/skt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_dp
// Datapath of the tracker: registers, covariance sums, serial gain divider,
// estimate and covariance multipliers, result register.
// ----------------------------------------------------------------------------
module skt_dp #(
  parameter int unsigned GAIN_FRAC_BITS = skt_pkg::GainFracBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // register writes
  input  logic                               cfg_we_i,
  input  logic [skt_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [skt_pkg::ValW-1:0]           cfg_data_i,
  // input beat
  input  logic signed [skt_pkg::ValW-1:0]    meas_i,
  input  logic                               restart_i,
  input  logic                               last_i,
  // control
  input  skt_pkg::cmd_t                      cmd_i,
  output skt_pkg::sts_t                      sts_o,
  // result beat
  output logic signed [skt_pkg::ValW-1:0]    estimate_o,
  output logic [skt_pkg::GainOutW-1:0]       gain_o,
  output logic [skt_pkg::StatusW-1:0]        status_o,
  output logic                               last_o
);

  localparam int unsigned G    = GAIN_FRAC_BITS;
  localparam int unsigned QW   = G + 1;
  localparam int unsigned NumW = G + 33;
  localparam int unsigned CntW = $clog2(QW);
  localparam int unsigned PeW  = 34 + QW;
  localparam int unsigned PcW  = 32 + QW;
  localparam int unsigned GrW  = G + 18;

  localparam logic [QW-1:0]   OneG  = QW'(1) << G;
  localparam logic [PeW-1:0]  HalfE = PeW'(1) << (G - 1);
  localparam logic [PcW-1:0]  HalfC = PcW'(1) << (G - 1);
  localparam logic [GrW-1:0]  HalfR = GrW'(1) << (G - 1);
  localparam logic [CntW-1:0] CntLast = CntW'(G);

  // configuration
  logic [31:0] qn_q, rn_q, init_est_q, init_cov_q;
  // filter state
  logic [31:0] est_q, cov_q;
  // per-item working registers
  logic signed [31:0]     meas_q;
  logic                   last_q;
  logic [31:0]            p_q;
  logic                   sat_q;
  logic [32:0]            den_q;
  logic                   zden_q;
  logic [32:0]            rem_q;
  logic [QW-1:0]          nlo_q;
  logic [QW-1:0]          quo_q;
  logic [CntW-1:0]        cnt_q;
  logic [QW-1:0]          g_q;
  logic [QW-1:0]          omg_q;
  logic signed [32:0]     diff_q;
  logic signed [PeW-1:0]  prod_est_q;
  logic [PcW-1:0]         prod_cov_q;
  // result register
  logic signed [31:0]     estimate_q;
  logic [16:0]            gain_q;
  skt_pkg::status_e       status_q;
  logic                   last_res_q;

  logic [32:0]            psum;
  logic [NumW-1:0]        num;
  logic [33:0]            shifted;
  logic [33:0]            trial;
  logic                   ge;
  logic [QW-1:0]          g_sel;
  logic signed [PeW-1:0]  rnd_e;
  logic signed [PeW-1:0]  upd_e;
  logic [PcW-1:0]         rnd_c;
  logic [PcW-1:0]         cov_new;
  logic [GrW-1:0]         g_rs;
  logic [31:0]            est_new;
  skt_pkg::status_e       status_new;

  assign psum    = {1'b0, cov_q} + {1'b0, qn_q};
  assign num     = {1'b0, p_q, G'(0)} + NumW'(den_q[32:1]);
  assign shifted = {rem_q, nlo_q[QW-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign ge      = !trial[33];
  assign g_sel   = zden_q ? '0 : ((quo_q > OneG) ? OneG : quo_q);
  assign rnd_e   = prod_est_q + $signed(HalfE);
  assign upd_e   = rnd_e >>> G;
  assign est_new = est_q + upd_e[31:0];
  assign rnd_c   = prod_cov_q + HalfC;
  assign cov_new = rnd_c >> G;
  assign g_rs    = (({GrW'(g_q)} << 16) + HalfR) >> G;

  always_comb begin
    if (zden_q) begin
      status_new = skt_pkg::StZeroDen;
    end else if (sat_q) begin
      status_new = skt_pkg::StCovSat;
    end else begin
      status_new = skt_pkg::StOk;
    end
  end

  assign sts_o.div_last = (cnt_q == CntLast);

  // registers and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qn_q       <= skt_pkg::ProcNoiseRst;
      rn_q       <= skt_pkg::MeasNoiseRst;
      init_est_q <= skt_pkg::InitEstRst;
      init_cov_q <= skt_pkg::InitCovRst;
      est_q      <= '0;
      cov_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          skt_pkg::CfgProcNoise: qn_q       <= cfg_data_i;
          skt_pkg::CfgMeasNoise: rn_q       <= cfg_data_i;
          skt_pkg::CfgInitEst:   init_est_q <= cfg_data_i;
          skt_pkg::CfgInitCov:   init_cov_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.capture && restart_i) begin
        est_q <= init_est_q;
        cov_q <= init_cov_q;
      end
      if (cmd_i.commit) begin
        est_q <= est_new;
        cov_q <= cov_new[31:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      meas_q <= meas_i;
      last_q <= last_i;
    end
    if (cmd_i.psum) begin
      p_q   <= psum[32] ? '1 : psum[31:0];
      sat_q <= psum[32];
    end
    if (cmd_i.dsum) begin
      den_q <= {1'b0, p_q} + {1'b0, rn_q};
    end
    if (cmd_i.nsum) begin
      rem_q  <= {1'b0, num[NumW-1:QW]};
      nlo_q  <= num[QW-1:0];
      quo_q  <= '0;
      cnt_q  <= '0;
      zden_q <= (den_q == '0);
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? trial[32:0] : shifted[32:0];
      nlo_q <= nlo_q << 1;
      quo_q <= {quo_q[QW-2:0], ge};
      cnt_q <= cnt_q + CntW'(1);
    end
    if (cmd_i.gsel) begin
      g_q    <= g_sel;
      diff_q <= {meas_q[31], meas_q} - {est_q[31], est_q};
    end
    if (cmd_i.mest) begin
      prod_est_q <= diff_q * $signed({1'b0, g_q});
      omg_q      <= OneG - g_q;
    end
    if (cmd_i.mcov) begin
      prod_cov_q <= PcW'(p_q) * PcW'(omg_q);
    end
    if (cmd_i.commit) begin
      estimate_q <= est_new;
      gain_q     <= g_rs[16:0];
      status_q   <= status_new;
      last_res_q <= last_q;
    end
  end

  assign estimate_o = estimate_q;
  assign gain_o     = gain_q;
  assign status_o   = status_q;
  assign last_o     = last_res_q;

endmodule

// File: src/skt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_checker
// Port-level checks of the Kalman tracker, bound to the top level.
// ----------------------------------------------------------------------------
module skt_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [skt_pkg::ValW-1:0]   estimate_i,
  input logic [skt_pkg::GainOutW-1:0]      gain_i,
  input logic [skt_pkg::StatusW-1:0]       status_i
);

  // one beat in flight at a time
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("tracker took a beat while busy");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (gain_i <= 17'd65536))
    else $error("gain above one");

  a_zero_den_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (status_i == skt_pkg::StZeroDen)) |-> (gain_i == '0))
    else $error("zero denominator with non-zero gain");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(estimate_i) && $stable(gain_i) && $stable(status_i)))
    else $error("stalled result changed");

endmodule

bind scalar_kalman_tracker skt_checker u_skt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (meas_i.valid),
  .in_ready_i  (meas_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .estimate_i  (res_o.estimate),
  .gain_i      (res_o.gain),
  .status_i    (res_o.status)
);
